FILE: hdl/mmps3d_pkg.sv
// Package with the beat types, register indexes and direction code constants.
package mmps3d_pkg;

  localparam int VALUE_BITS      = 16;
  localparam int DIR_BITS        = 8;
  localparam int CFG_INDEX_BITS  = 8;
  localparam int CFG_DATA_BITS   = 16;
  localparam int WIDTH_REG_BITS  = 9;
  localparam int HEIGHT_REG_BITS = 9;
  localparam int DEPTH_REG_BITS  = 16;

  localparam int DEF_MAX_WIDTH   = 256;
  localparam int DEF_MAX_HEIGHT  = 256;

  localparam int NUM_NBR         = 13;
  localparam int NBR_IDX_BITS    = 4;
  localparam int REV_CODE_BASE   = 27;

  localparam logic [DIR_BITS-1:0] DIR_SEED      = 8'h80;
  localparam logic [DIR_BITS-1:0] DIR_SAT       = 8'h40;
  localparam logic [DIR_BITS-1:0] DIR_FLAG_MASK = DIR_SEED | DIR_SAT;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_VOL_WIDTH    = 8'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_VOL_HEIGHT   = 8'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_VOL_DEPTH    = 8'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SCAN_REVERSE = 8'd3;

  typedef struct packed {
    logic [VALUE_BITS-1:0] intensity;
    logic [VALUE_BITS-1:0] current_value;
    logic [DIR_BITS-1:0]   dir_code;
  } voxel_in_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] new_value;
    logic [DIR_BITS-1:0]   new_dir;
    logic                  changed;
    logic                  sweep_done;
  } voxel_out_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0]   val;
    logic [NBR_IDX_BITS-1:0] idx;
  } nbr_cand_t;

endpackage

FILE: hdl/maxmin_path_sweep_3d_top.sv
// Top level of the 3D max-min path raster sweep with its neighbour delay lines.
//
//  Channel   Handshake                    Payload              Direction
//  -------   --------------------------   ------------------   ---------
//  item      item_valid, item_stall       item (voxel_in_t)    into block
//  result    result_valid, result_stall   result (voxel_out_t) out of block
//  cfg       cfg_valid, cfg_ready         cfg_index, cfg_data  into block
//
// The block takes one voxel beat per clock while the result side does not stall
// and returns one result beat per voxel through the item register and the result
// register. The rate is set by the update stage: the strength produced for a voxel
// is the distance-one neighbour of the very next voxel, so the neighbour compare
// tree and the update sit in one stage between the item and result registers.
// Reset (rst, synchronous, active high) clears the handshake state, the stream
// position and the delay line pointers, and loads the default configuration; the
// delay line contents are not cleared and there is no clearing pass after reset.
// A stalled result holds the item register, which then stalls the item side.
module maxmin_path_sweep_3d_top
  import mmps3d_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      item_valid,
  output logic                      item_stall,
  input  voxel_in_t                 item,
  output logic                      result_valid,
  input  logic                      result_stall,
  output voxel_out_t                result,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  // Widths of clamped sizes and of the stream position counters.
  localparam int DW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int PW = DW + HW;
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);

  // The produced strengths run through a chain of registers and four circular
  // buffers. Buffer A brings the stream to distance w-1, buffer B from distance w
  // to s-w-1, buffers C and D each span one row less two entries. Three register
  // taps follow each buffer, giving the 13 causal neighbours.
  localparam int DEPTH_RL = MAX_WIDTH - 2;
  localparam int DEPTH_B  = MAX_WIDTH * MAX_HEIGHT - 2 * MAX_WIDTH - 2;
  localparam int AW_RL    = (DEPTH_RL > 1) ? $clog2(DEPTH_RL) : 1;
  localparam int AW_B     = (DEPTH_B > 1) ? $clog2(DEPTH_B) : 1;

  // Configuration registers.
  logic [WIDTH_REG_BITS-1:0]  vol_width;
  logic [HEIGHT_REG_BITS-1:0] vol_height;
  logic [DEPTH_REG_BITS-1:0]  vol_depth;
  logic                       scan_reverse;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vol_width    <= WIDTH_REG_BITS'(256);
      vol_height   <= HEIGHT_REG_BITS'(256);
      vol_depth    <= DEPTH_REG_BITS'(256);
      scan_reverse <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_VOL_WIDTH:    vol_width    <= cfg_data[WIDTH_REG_BITS-1:0];
        CFG_VOL_HEIGHT:   vol_height   <= cfg_data[HEIGHT_REG_BITS-1:0];
        CFG_VOL_DEPTH:    vol_depth    <= cfg_data[DEPTH_REG_BITS-1:0];
        CFG_SCAN_REVERSE: scan_reverse <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Sizes clamped into range, and the limits derived from them. These are
  // registered behind the configuration registers, so an item accepted in the
  // same cycle as a configuration write meets the old limits in the update stage.
  logic [DW-1:0]             w_cl;
  logic [HW-1:0]             h_cl;
  logic [PW-1:0]             lim_b_full;
  logic [CW-1:0]             w_last;
  logic [RW-1:0]             h_last;
  logic [DEPTH_REG_BITS-1:0] d_last;
  logic [AW_RL-1:0]          lim_rl;
  logic [AW_B-1:0]           lim_b;

  always_comb begin
    if (vol_width < WIDTH_REG_BITS'(3)) begin
      w_cl = DW'(3);
    end else if (32'(vol_width) > 32'(MAX_WIDTH)) begin
      w_cl = DW'(MAX_WIDTH);
    end else begin
      w_cl = DW'(vol_width);
    end
    if (vol_height < HEIGHT_REG_BITS'(3)) begin
      h_cl = HW'(3);
    end else if (32'(vol_height) > 32'(MAX_HEIGHT)) begin
      h_cl = HW'(MAX_HEIGHT);
    end else begin
      h_cl = HW'(vol_height);
    end
    lim_b_full = PW'(w_cl) * PW'(h_cl) - (PW'(w_cl) << 1) - PW'(3);
  end

  always_ff @(posedge clk) begin
    w_last <= CW'(w_cl - DW'(1));
    h_last <= RW'(h_cl - HW'(1));
    d_last <= (vol_depth < DEPTH_REG_BITS'(3)) ? DEPTH_REG_BITS'(2)
                                                : vol_depth - DEPTH_REG_BITS'(1);
    lim_rl <= AW_RL'(w_cl - DW'(3));
    lim_b  <= lim_b_full[AW_B-1:0];
  end

  // Handshake: the item register feeds the update stage, which loads the result
  // register whenever that register is empty or being drained.
  voxel_in_t item_q;
  logic      item_q_valid;
  logic      out_open;
  logic      fire;
  logic      take;

  assign out_open   = !result_valid || !result_stall;
  assign fire       = item_q_valid && out_open;
  assign item_stall = item_q_valid && !out_open;
  assign take       = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_q_valid <= 1'b0;
    end else begin
      item_q_valid <= take || (item_q_valid && !fire);
    end
    if (take) begin
      item_q <= item;
    end
  end

  // Stream position of the voxel in the update stage.
  logic [CW-1:0]             col;
  logic [RW-1:0]             row;
  logic [DEPTH_REG_BITS-1:0] slice;
  logic                      col_last;
  logic                      row_last;
  logic                      sl_last;
  logic                      interior;

  assign col_last = col >= w_last;
  assign row_last = row >= h_last;
  assign sl_last  = slice >= d_last;
  assign interior = (col != '0) && !col_last && (row != '0) && !row_last &&
                    (slice != '0) && !sl_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      col   <= '0;
      row   <= '0;
      slice <= '0;
    end else if (fire) begin
      if (col_last) begin
        col <= '0;
        if (row_last) begin
          row <= '0;
          slice <= sl_last ? '0 : slice + DEPTH_REG_BITS'(1);
        end else begin
          row <= row + RW'(1);
        end
      end else begin
        col <= col + CW'(1);
      end
    end
  end

  // Neighbour taps and delay buffers.
  logic [VALUE_BITS-1:0] t1;
  logic [VALUE_BITS-1:0] a0, a1, a2;
  logic [VALUE_BITS-1:0] b0, b1, b2;
  logic [VALUE_BITS-1:0] c0, c1, c2;
  logic [VALUE_BITS-1:0] d0, d1, d2;
  logic [VALUE_BITS-1:0] mem_a [DEPTH_RL];
  logic [VALUE_BITS-1:0] mem_b [DEPTH_B];
  logic [VALUE_BITS-1:0] mem_c [DEPTH_RL];
  logic [VALUE_BITS-1:0] mem_d [DEPTH_RL];
  logic [AW_RL-1:0]      ptr_a, ptr_c, ptr_d;
  logic [AW_B-1:0]       ptr_b;
  logic [VALUE_BITS-1:0] nval;
  logic [DIR_BITS-1:0]   ndir;
  logic                  upd;

  // A configuration write restarts the pointers as well, so a buffer that gets
  // shorter between sweeps never leaves its pointer past the new end and skips
  // an entry.
  always_ff @(posedge clk) begin
    if (rst || (cfg_valid && cfg_ready)) begin
      ptr_a <= '0;
      ptr_b <= '0;
      ptr_c <= '0;
      ptr_d <= '0;
    end else if (fire) begin
      ptr_a <= (ptr_a >= lim_rl) ? '0 : ptr_a + AW_RL'(1);
      ptr_b <= (ptr_b >= lim_b)  ? '0 : ptr_b + AW_B'(1);
      ptr_c <= (ptr_c >= lim_rl) ? '0 : ptr_c + AW_RL'(1);
      ptr_d <= (ptr_d >= lim_rl) ? '0 : ptr_d + AW_RL'(1);
    end
  end

  // Each buffer reads its oldest entry before overwriting it with the new one.
  always_ff @(posedge clk) begin
    if (fire) begin
      a0 <= mem_a[ptr_a];
      mem_a[ptr_a] <= nval;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      b0 <= mem_b[ptr_b];
      mem_b[ptr_b] <= a1;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      c0 <= mem_c[ptr_c];
      mem_c[ptr_c] <= b1;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      d0 <= mem_d[ptr_d];
      mem_d[ptr_d] <= c1;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      t1 <= nval;
      a1 <= a0;
      a2 <= a1;
      b1 <= b0;
      b2 <= b1;
      c1 <= c0;
      c2 <= c1;
      d1 <= d0;
      d2 <= d1;
    end
  end

  // Neighbours in stream order from the farthest, which is also the tie order.
  logic [VALUE_BITS-1:0] nbr [NUM_NBR];

  assign nbr[0]  = d2;
  assign nbr[1]  = d1;
  assign nbr[2]  = d0;
  assign nbr[3]  = c2;
  assign nbr[4]  = c1;
  assign nbr[5]  = c0;
  assign nbr[6]  = b2;
  assign nbr[7]  = b1;
  assign nbr[8]  = b0;
  assign nbr[9]  = a2;
  assign nbr[10] = a1;
  assign nbr[11] = a0;
  assign nbr[12] = t1;

  // Maximum tree. The left candidate wins ties, which keeps the first maximum.
  nbr_cand_t lv0 [NUM_NBR];
  nbr_cand_t lv1 [7];
  nbr_cand_t lv2 [4];
  nbr_cand_t lv3 [2];
  nbr_cand_t best;

  always_comb begin
    for (int i = 0; i < NUM_NBR; i++) begin
      lv0[i].val = nbr[i];
      lv0[i].idx = NBR_IDX_BITS'(i);
    end
    for (int i = 0; i < 6; i++) begin
      lv1[i] = (lv0[2*i+1].val > lv0[2*i].val) ? lv0[2*i+1] : lv0[2*i];
    end
    lv1[6] = lv0[12];
    for (int i = 0; i < 3; i++) begin
      lv2[i] = (lv1[2*i+1].val > lv1[2*i].val) ? lv1[2*i+1] : lv1[2*i];
    end
    lv2[3] = lv1[6];
    for (int i = 0; i < 2; i++) begin
      lv3[i] = (lv2[2*i+1].val > lv2[2*i].val) ? lv2[2*i+1] : lv2[2*i];
    end
    best = (lv3[1].val > lv3[0].val) ? lv3[1] : lv3[0];
  end

  // Update rule: only an interior voxel with neither flag set can improve, and
  // only when both the best neighbour and its own intensity beat its strength.
  logic [DIR_BITS-1:0] code;

  always_comb begin
    upd  = interior && ((item_q.dir_code & DIR_FLAG_MASK) == '0) &&
           (best.val > item_q.current_value) &&
           (item_q.intensity > item_q.current_value);
    code = scan_reverse ? DIR_BITS'(REV_CODE_BASE) - DIR_BITS'(best.idx)
                        : DIR_BITS'(best.idx) + DIR_BITS'(1);
    nval = item_q.current_value;
    ndir = item_q.dir_code;
    if (upd) begin
      if (best.val > item_q.intensity) begin
        nval = item_q.intensity;
        ndir = code | DIR_SAT;
      end else begin
        nval = best.val;
        ndir = code;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (fire) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
    if (fire) begin
      result.new_value  <= nval;
      result.new_dir    <= ndir;
      result.changed    <= upd;
      result.sweep_done <= col_last && row_last && sl_last;
    end
  end

endmodule

FILE: tb/tb_maxmin_path_sweep_3d_top.sv
// Self-checking testbench for the 3D max-min path raster sweep block.
`timescale 1ns / 100ps

module tb_maxmin_path_sweep_3d_top;
  import mmps3d_pkg::*;

  localparam int CLK_PERIOD     = 12;
  localparam int RESET_CYCLES   = 11;
  localparam int MAX_W          = DEF_MAX_WIDTH;
  localparam int MAX_H          = DEF_MAX_HEIGHT;
  // The strength history spans one plane, one row and two more voxels.
  localparam int HIST_DEPTH     = MAX_W * MAX_H + MAX_W + 2;
  localparam int RANDOM_ITEMS   = 800;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int MAX_REPORTS    = 10;

  // Content styles for random voxels: full range, a narrow range that makes
  // ties between neighbours common, and the corner values of the field.
  typedef enum int {FILL_FULL, FILL_NARROW, FILL_EXTREME} fill_style_t;

  // Every input of the block has a known value from time zero.
  logic                      clk          = 1'b0;
  logic                      rst          = 1'b1;
  logic                      item_valid   = 1'b0;
  logic                      item_stall;
  voxel_in_t                 item         = '0;
  logic                      result_valid;
  logic                      result_stall = 1'b0;
  voxel_out_t                result;
  logic                      cfg_valid    = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index    = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data     = '0;

  maxmin_path_sweep_3d_top uut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Shadow copy of the block's registers, stream position and strength history.
  logic [WIDTH_REG_BITS-1:0]  reg_width   = 9'd256;
  logic [HEIGHT_REG_BITS-1:0] reg_height  = 9'd256;
  logic [DEPTH_REG_BITS-1:0]  reg_depth   = 16'd256;
  logic                       reg_reverse = 1'b0;
  bit [VALUE_BITS-1:0]        strength_hist [HIST_DEPTH];
  int unsigned                hist_wr   = 0;
  int unsigned                col_pos   = 0;
  int unsigned                row_pos   = 0;
  int unsigned                slice_pos = 0;

  // Results predicted for accepted voxels, oldest first.
  voxel_out_t expected_results [$];
  voxel_out_t want_beat;

  // Pressure knobs, in percent of cycles.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // Run statistics.
  int mismatches      = 0;
  int items_sent      = 0;
  int results_checked = 0;
  int updates_seen    = 0;
  int clipped_seen    = 0;
  int volumes_swept   = 0;
  int quiet_cycles    = 0;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Register values outside the legal range saturate into it.
  function automatic int unsigned eff_width();
    return (reg_width < 3) ? 3 : ((reg_width > MAX_W) ? MAX_W : reg_width);
  endfunction

  function automatic int unsigned eff_height();
    return (reg_height < 3) ? 3 : ((reg_height > MAX_H) ? MAX_H : reg_height);
  endfunction

  function automatic int unsigned eff_depth();
    return (reg_depth < 3) ? 3 : reg_depth;
  endfunction

  function automatic int unsigned vol_voxels();
    return eff_width() * eff_height() * eff_depth();
  endfunction

  function automatic void load_register(logic [CFG_INDEX_BITS-1:0] idx,
                                        logic [CFG_DATA_BITS-1:0] data);
    case (idx)
      CFG_VOL_WIDTH:    reg_width   = data[WIDTH_REG_BITS-1:0];
      CFG_VOL_HEIGHT:   reg_height  = data[HEIGHT_REG_BITS-1:0];
      CFG_VOL_DEPTH:    reg_depth   = data[DEPTH_REG_BITS-1:0];
      CFG_SCAN_REVERSE: reg_reverse = data[0];
      default: ;
    endcase
  endfunction

  // Works out the strength and direction code of one voxel, then advances the
  // history and the stream position exactly as the block does.
  function automatic voxel_out_t predict_voxel(voxel_in_t v);
    int unsigned         w, h, d, s, best_i, i, code;
    int unsigned         nbr_dist [NUM_NBR];
    logic [VALUE_BITS-1:0] best, cand;
    bit                  col_last, row_last, sl_last, interior;
    voxel_out_t          r;
    w = eff_width();
    h = eff_height();
    d = eff_depth();
    s = w * h;
    r.new_value  = v.current_value;
    r.new_dir    = v.dir_code;
    r.changed    = 1'b0;
    r.sweep_done = 1'b0;
    col_last = (col_pos >= w - 1);
    row_last = (row_pos >= h - 1);
    sl_last  = (slice_pos >= d - 1);
    interior = (col_pos >= 1) && !col_last && (row_pos >= 1) && !row_last &&
               (slice_pos >= 1) && !sl_last;
    if (interior && ((v.dir_code & DIR_FLAG_MASK) == '0)) begin
      // Stream distances of the 13 neighbours already visited.
      nbr_dist[0] = s + w + 1; nbr_dist[1]  = s + w; nbr_dist[2]  = s + w - 1;
      nbr_dist[3] = s + 1;     nbr_dist[4]  = s;     nbr_dist[5]  = s - 1;
      nbr_dist[6] = s - w + 1; nbr_dist[7]  = s - w; nbr_dist[8]  = s - w - 1;
      nbr_dist[9] = w + 1;     nbr_dist[10] = w;     nbr_dist[11] = w - 1;
      nbr_dist[12] = 1;
      best   = strength_hist[(hist_wr + HIST_DEPTH - nbr_dist[0]) % HIST_DEPTH];
      best_i = 0;
      for (i = 1; i < NUM_NBR; i++) begin
        cand = strength_hist[(hist_wr + HIST_DEPTH - nbr_dist[i]) % HIST_DEPTH];
        // Strictly greater, so a tie keeps the earlier neighbour.
        if (cand > best) begin
          best   = cand;
          best_i = i;
        end
      end
      if (best > v.current_value && v.intensity > v.current_value) begin
        code = reg_reverse ? (REV_CODE_BASE - best_i) : (best_i + 1);
        if (best > v.intensity) begin
          r.new_value = v.intensity;
          r.new_dir   = code[DIR_BITS-1:0] | DIR_SAT;
        end else begin
          r.new_value = best;
          r.new_dir   = code[DIR_BITS-1:0];
        end
        r.changed = 1'b1;
      end
    end
    strength_hist[hist_wr] = r.new_value;
    hist_wr = (hist_wr + 1) % HIST_DEPTH;
    if (col_last) begin
      col_pos = 0;
      if (row_last) begin
        row_pos = 0;
        if (sl_last) begin
          slice_pos    = 0;
          r.sweep_done = 1'b1;
        end else begin
          slice_pos++;
        end
      end else begin
        row_pos++;
      end
    end else begin
      col_pos++;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic logic [VALUE_BITS-1:0] pick_extreme();
    case ($urandom_range(3))
      0:       return 16'h0000;
      1:       return 16'h0001;
      2:       return 16'hFFFE;
      default: return 16'hFFFF;
    endcase
  endfunction

  function automatic voxel_in_t make_voxel(fill_style_t style);
    voxel_in_t v;
    case (style)
      FILL_NARROW: begin
        v.intensity     = VALUE_BITS'($urandom_range(7));
        v.current_value = VALUE_BITS'($urandom_range(7));
      end
      FILL_EXTREME: begin
        v.intensity     = pick_extreme();
        v.current_value = pick_extreme();
      end
      default: begin
        v.intensity     = VALUE_BITS'($urandom);
        v.current_value = VALUE_BITS'($urandom);
      end
    endcase
    // Most voxels carry no seed or saturated flag so that they can be updated.
    if ($urandom_range(99) < 80)
      v.dir_code = DIR_BITS'($urandom_range(63));
    else
      v.dir_code = DIR_BITS'($urandom_range(255));
    return v;
  endfunction

  task automatic set_pressure(input int send_pct, input int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  // Sends one voxel beat, with random idle cycles ahead of it, and records the
  // predicted result once the block takes it.
  task automatic send_voxel(input voxel_in_t v);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= v;
    do @(posedge clk); while (item_stall);
    expected_results.push_back(predict_voxel(v));
    items_sent++;
  endtask

  // Programs all four registers. The block is drained first, so the registers
  // only ever change between sweeps.
  task automatic set_volume(input logic [CFG_DATA_BITS-1:0] w_raw,
                            input logic [CFG_DATA_BITS-1:0] h_raw,
                            input logic [CFG_DATA_BITS-1:0] d_raw,
                            input logic [CFG_DATA_BITS-1:0] rev_raw);
    logic [CFG_INDEX_BITS-1:0] idx  [4];
    logic [CFG_DATA_BITS-1:0]  data [4];
    int i;
    idx[0] = CFG_VOL_WIDTH;    data[0] = w_raw;
    idx[1] = CFG_VOL_HEIGHT;   data[1] = h_raw;
    idx[2] = CFG_VOL_DEPTH;    data[2] = d_raw;
    idx[3] = CFG_SCAN_REVERSE; data[3] = rev_raw;
    item_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    for (i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= data[i];
      do @(posedge clk); while (!cfg_ready);
      load_register(idx[i], data[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  // Streams one whole volume. With hold_mid set, the sender stops partway
  // and waits until every outstanding result has come back.
  task automatic send_volume(input fill_style_t style, input bit hold_mid);
    int n, i, hold_at;
    n       = vol_voxels();
    hold_at = hold_mid ? $urandom_range(n - 1, 1) : -1;
    for (i = 0; i < n; i++) begin
      if (i == hold_at) begin
        item_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
      end
      send_voxel(make_voxel(style));
    end
    volumes_swept++;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Two 5x3x3 volumes, forward then reverse, whose three interior voxels hit
  // the special cases. Border voxels carry extreme field values and a pattern
  // of equal strengths so that the neighbour compare sees ties.
  task automatic test_directed_cases();
    voxel_in_t v;
    int rev, i;
    set_pressure(0, 0);
    for (rev = 0; rev < 2; rev++) begin
      set_volume(16'd5, 16'd3, 16'd3, CFG_DATA_BITS'(rev));
      for (i = 0; i < vol_voxels(); i++) begin
        v.intensity     = i[0] ? 16'hFFFF : 16'h0000;
        v.current_value = (i % 4 == 0) ? 16'd5000 : 16'd100;
        v.dir_code      = i[1] ? 8'hFF : 8'h00;
        case (i)
          21: begin
            if (rev == 0) begin
              // Plain update, intensity above the best neighbour.
              v.intensity = 16'hFFFF; v.current_value = 16'd0; v.dir_code = '0;
            end else begin
              // Saturated voxel passes through.
              v.intensity = 16'hFFFF; v.current_value = 16'd0;
              v.dir_code  = DIR_SAT | 8'd5;
            end
          end
          22: begin
            if (rev == 0) begin
              // Intensity clips the value, so the code gets the saturated flag.
              v.intensity = 16'd10; v.current_value = 16'd0; v.dir_code = '0;
            end else begin
              // Current strength already at the top: no improvement.
              v.intensity = 16'hFFFF; v.current_value = 16'hFFFF; v.dir_code = '0;
            end
          end
          23: begin
            if (rev == 0) begin
              // Seed voxel passes through.
              v.intensity = 16'hFFFF; v.current_value = 16'd0; v.dir_code = DIR_SEED;
            end else begin
              // Intensity not above the current strength blocks the reverse update.
              v.intensity = 16'd50; v.current_value = 16'd50; v.dir_code = '0;
            end
          end
          default: ;
        endcase
        send_voxel(v);
      end
      volumes_swept++;
    end
  endtask

  // Sizes below the legal range, and register data with stray upper bits,
  // must saturate or mask exactly like the shadow registers.
  task automatic test_size_saturation();
    set_pressure(38, 38);
    set_volume(16'd0, 16'd1, 16'd0, 16'd0);
    send_volume(FILL_FULL, 1'b0);
    set_volume(16'd2, 16'd2, 16'd1, 16'd1);
    send_volume(FILL_NARROW, 1'b0);
    set_pressure(0, 0);
    // Stray bits above the width and height fields and above the direction bit.
    set_volume(16'hFE04, 16'hFE03, 16'd4, 16'hFFFF);
    send_volume(FILL_FULL, 1'b0);
    set_volume(16'd3, 16'hFE05, 16'd3, 16'hFFFE);
    send_volume(FILL_EXTREME, 1'b0);
  endtask

  // A tall stack of the smallest slices, so the slice counter runs a long way
  // before the sweep ends.
  task automatic test_deep_volume();
    set_pressure(0, 0);
    set_volume(16'd3, 16'd3, 16'd40, CFG_DATA_BITS'($urandom_range(1)));
    send_volume(FILL_FULL, 1'b0);
  endtask

  // Small volumes of random shape, direction and content, cycling through the
  // idle and stall phases. Every third volume holds the sender partway.
  task automatic test_random_volumes();
    int start, vol;
    logic [CFG_DATA_BITS-1:0] w_raw, h_raw, d_raw;
    start = items_sent;
    vol   = 0;
    while (items_sent - start < RANDOM_ITEMS) begin
      case (vol % 4)
        0: set_pressure(0, 0);
        1: set_pressure(70, 0);
        2: set_pressure(0, 70);
        default: set_pressure(38, 38);
      endcase
      w_raw = CFG_DATA_BITS'(($urandom_range(9) == 0) ? $urandom_range(2)
                                                       : $urandom_range(8, 3));
      h_raw = CFG_DATA_BITS'(($urandom_range(9) == 0) ? $urandom_range(2)
                                                       : $urandom_range(6, 3));
      d_raw = CFG_DATA_BITS'(($urandom_range(9) == 0) ? $urandom_range(2)
                                                       : $urandom_range(6, 3));
      set_volume(w_raw, h_raw, d_raw, CFG_DATA_BITS'($urandom_range(1)));
      send_volume(fill_style_t'($urandom_range(2)), (vol % 3) == 0);
      vol++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stall, checking, watchdog
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (rst)
      result_stall <= 1'b0;
    else
      result_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  task automatic note_mismatch(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("mismatch on result %0d, %s: expected %0h, got %0h",
               results_checked, field, want, got);
  endtask

  // Each result beat is compared field by field with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      results_checked++;
      if (expected_results.size() == 0) begin
        note_mismatch("beat with nothing pending", '0, 32'(result));
      end else begin
        want_beat = expected_results.pop_front();
        if (result.new_value !== want_beat.new_value)
          note_mismatch("new_value", 32'(want_beat.new_value), 32'(result.new_value));
        if (result.new_dir !== want_beat.new_dir)
          note_mismatch("new_dir", 32'(want_beat.new_dir), 32'(result.new_dir));
        if (result.changed !== want_beat.changed)
          note_mismatch("changed", 32'(want_beat.changed), 32'(result.changed));
        if (result.sweep_done !== want_beat.sweep_done)
          note_mismatch("sweep_done", 32'(want_beat.sweep_done),
                        32'(result.sweep_done));
        if (want_beat.changed) updates_seen++;
        if (want_beat.changed && (want_beat.new_dir & DIR_SAT) != '0) clipped_seen++;
      end
    end
  end

  // The run is declared hung when no beat moves on any channel for too long.
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat moved for %0d cycles", quiet_cycles);
      $display("tb_maxmin_path_sweep_3d_top: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_size_saturation();
    test_deep_volume();
    test_random_volumes();

    // Drain, then give the block a few more cycles to show any stray beat.
    item_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) note_mismatch("results left over", '0, '0);

    $display("swept %0d volumes, %0d voxels, %0d result beats checked",
             volumes_swept, items_sent, results_checked);
    $display("%0d voxels updated, %0d of them clipped by intensity, %0d mismatches",
             updates_seen, clipped_seen, mismatches);
    if (mismatches == 0)
      $display("tb_maxmin_path_sweep_3d_top: clean");
    else
      $display("tb_maxmin_path_sweep_3d_top: errors");
    $finish;
  end

endmodule
